// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

// File: src/ll1tpe_pkg.sv
// ----------------------------------------------------------------------------
// LL(1) parse engine package
// Field widths, codes and the types passed between front, back and result queue.
// ----------------------------------------------------------------------------
package ll1tpe_pkg;

   localparam int SYM_W       = 5;
   localparam int KIND_W      = 2;
   localparam int ACT_W       = 3;
   localparam int CNT_W       = 3;
   localparam int VERD_W      = 2;
   localparam int CAUSE_W     = 3;
   localparam int DEPTH_W     = 7;
   localparam int LIMIT_W     = 12;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 12;
   localparam int ENTRY_SLOTS = 4;
   localparam int OP_W        = 2;

   // Item kinds
   localparam logic [KIND_W-1:0] KIND_TWRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_START  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SYMBOL = 2'd2;

   // Table actions
   localparam logic [ACT_W-1:0] ACT_REJECT      = 3'd0;
   localparam logic [ACT_W-1:0] ACT_ACCEPT      = 3'd1;
   localparam logic [ACT_W-1:0] ACT_POP_RETAIN  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_POP_ADVANCE = 3'd3;
   localparam logic [ACT_W-1:0] ACT_REPLACE     = 3'd4;

   // Verdicts
   localparam logic [VERD_W-1:0] VERD_PARSING = 2'd0;
   localparam logic [VERD_W-1:0] VERD_ACCEPT  = 2'd1;
   localparam logic [VERD_W-1:0] VERD_REJECT  = 2'd2;

   // Reject causes
   localparam logic [CAUSE_W-1:0] CAUSE_NONE      = 3'd0;
   localparam logic [CAUSE_W-1:0] CAUSE_TABLE     = 3'd1;
   localparam logic [CAUSE_W-1:0] CAUSE_OVERFLOW  = 3'd2;
   localparam logic [CAUSE_W-1:0] CAUSE_UNDERFLOW = 3'd3;
   localparam logic [CAUSE_W-1:0] CAUSE_STEPS     = 3'd4;

   // Configuration register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_BOTTOM = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT  = 2'd2;

   localparam logic [SYM_W-1:0]   RST_BOTTOM = 5'd0;
   localparam logic [SYM_W-1:0]   RST_START  = 5'd1;
   localparam logic [LIMIT_W-1:0] RST_LIMIT  = 12'd1024;

   // Commands handed from front to back
   localparam logic [OP_W-1:0] OP_NOP    = 2'd0;
   localparam logic [OP_W-1:0] OP_TWRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_START  = 2'd2;
   localparam logic [OP_W-1:0] OP_SYMBOL = 2'd3;

   typedef logic [SYM_W-1:0] sym_type;

   typedef struct packed {
      logic [ACT_W-1:0]           act;
      logic [CNT_W-1:0]           cnt;
      sym_type [ENTRY_SLOTS-1:0]  syms;
   } entry_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      sym_type         top;
      sym_type         look;
      logic            look_ok;
      entry_type       entry;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_beat_type;

   typedef struct packed {
      logic [VERD_W-1:0]  verdict;
      logic [CAUSE_W-1:0] cause;
      logic [DEPTH_W-1:0] depth;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } rsp_beat_type;

endpackage

// File: src/ll1tpe_front.sv
// ----------------------------------------------------------------------------
// LL(1) parse engine front
// Accepts request beats, classifies them into commands and queues them.
// ----------------------------------------------------------------------------
module ll1tpe_front import ll1tpe_pkg::*; #(
   parameter int SYMBOL_COUNT = 32,
   parameter int MAX_PUSH     = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               hold,
   input  logic               req_push,
   output logic               req_full,
   input  logic [KIND_W-1:0]  req_kind,
   input  logic [SYM_W-1:0]   req_top_symbol,
   input  logic [SYM_W-1:0]   req_look_symbol,
   input  logic [ACT_W-1:0]   req_action,
   input  logic [CNT_W-1:0]   req_push_count,
   input  logic [SYM_W-1:0]   req_push_first,
   input  logic [SYM_W-1:0]   req_push_second,
   input  logic [SYM_W-1:0]   req_push_third,
   input  logic [SYM_W-1:0]   req_push_fourth,
   output cmd_beat_type       cmd_out,
   input  logic               cmd_pop
);

   localparam int PUSH_SLOTS = (MAX_PUSH < ENTRY_SLOTS) ? MAX_PUSH : ENTRY_SLOTS;

   cmd_type    cmd_new;
   logic       top_ok;
   logic       look_ok;
   logic       push_ok;

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign top_ok  = int'(req_top_symbol) < SYMBOL_COUNT;
   assign look_ok = int'(req_look_symbol) < SYMBOL_COUNT;

   // Classify the beat and saturate the push count
   always_comb begin
      cmd_new              = '0;
      cmd_new.top          = req_top_symbol;
      cmd_new.look         = req_look_symbol;
      cmd_new.look_ok      = look_ok;
      cmd_new.entry.act    = req_action;
      cmd_new.entry.syms[0] = req_push_first;
      cmd_new.entry.syms[1] = req_push_second;
      cmd_new.entry.syms[2] = req_push_third;
      cmd_new.entry.syms[3] = req_push_fourth;
      if (int'(req_push_count) > PUSH_SLOTS) begin
         cmd_new.entry.cnt = CNT_W'(PUSH_SLOTS);
      end else begin
         cmd_new.entry.cnt = req_push_count;
      end
      case (req_kind)
         KIND_TWRITE: begin
            cmd_new.op = (top_ok && look_ok) ? OP_TWRITE : OP_NOP;
         end
         KIND_START: begin
            cmd_new.op = OP_START;
         end
         KIND_SYMBOL: begin
            cmd_new.op = OP_SYMBOL;
         end
         default: begin
            cmd_new.op = OP_NOP;
         end
      endcase
   end

   assign req_full = (count_ff == 2'd2) || hold;
   assign push_ok  = req_push && !req_full;

   always_comb begin
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !cmd_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push_ok && cmd_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign cmd_out.valid = (count_ff != 2'd0);
   assign cmd_out.cmd   = q_ff[rd_ptr_ff];

endmodule

// File: src/ll1tpe_back.sv
// ----------------------------------------------------------------------------
// LL(1) parse engine back
// Owns the parse table, the symbol stack and the configuration; runs commands.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ll1tpe_back import ll1tpe_pkg::*; #(
   parameter int SYMBOL_COUNT = 32,
   parameter int STACK_DEPTH  = 64,
   parameter int MAX_PUSH     = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  cmd_beat_type          cmd_in,
   output logic                  cmd_pop,
   input  logic                  rsp_full,
   output rsp_beat_type          rsp_out,
   output logic                  clearing
);

   localparam int PUSH_SLOTS = (MAX_PUSH < ENTRY_SLOTS) ? MAX_PUSH : ENTRY_SLOTS;
   localparam int TBL_ROWS   = (SYMBOL_COUNT < (1 << SYM_W)) ? SYMBOL_COUNT : (1 << SYM_W);
   localparam int RW         = $clog2(TBL_ROWS);
   localparam int TA_W       = RW + SYM_W;
   localparam int TBL_DEPTH  = TBL_ROWS << SYM_W;
   localparam int TW         = ACT_W + CNT_W + SYM_W * PUSH_SLOTS;
   localparam int SP_W       = $clog2(STACK_DEPTH + 1);
   localparam int SA_W       = $clog2(STACK_DEPTH);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_START2 = 3'd2;
   localparam logic [2:0] ST_LOOK   = 3'd3;
   localparam logic [2:0] ST_TOPRD  = 3'd4;
   localparam logic [2:0] ST_ACT    = 3'd5;
   localparam logic [2:0] ST_PUSH   = 3'd6;

   // Configuration
   sym_type              bottom_ff;
   sym_type              start_ff;
   logic [LIMIT_W-1:0]   limit_ff;

   // Sequencer state
   logic [2:0]           state_ff, state_in;
   logic [SP_W-1:0]      sp_ff, sp_in;
   sym_type              top_ff, top_in;
   logic                 stale_ff, stale_in;
   logic [VERD_W-1:0]    verdict_ff, verdict_in;
   logic [CAUSE_W-1:0]   cause_ff, cause_in;
   logic [LIMIT_W-1:0]   steps_ff, steps_in;
   sym_type              look_ff, look_in;
   logic                 look_ok_ff, look_ok_in;
   logic [1:0]           idx_ff, idx_in;
   logic [SP_W-1:0]      base_ff, base_in;
   logic [TA_W-1:0]      clr_addr_ff, clr_addr_in;

   // Memories
   logic [TW-1:0]        tbl_ram [TBL_DEPTH];
   logic [TW-1:0]        tbl_q_ff;
   sym_type              stk_ram [STACK_DEPTH];
   sym_type              stk_q_ff;

   logic                 tbl_we, tbl_re;
   logic [TA_W-1:0]      tbl_waddr, tbl_raddr;
   logic [TW-1:0]        tbl_wdata, pack_word;
   logic                 stk_we, stk_re;
   logic [SA_W-1:0]      stk_waddr, stk_raddr;
   sym_type              stk_wdata;

   entry_type            ent;
   logic                 emit;
   logic [VERD_W-1:0]    emit_verdict;
   logic [CAUSE_W-1:0]   emit_cause;
   logic [SP_W+DEPTH_W-1:0] sp_wide;

   logic                 step_over;
   logic [SP_W:0]        repl_sum;
   logic                 repl_ovf;
   logic [SP_W-1:0]      sp_less;
   logic [SP_W-1:0]      push_addr;
   logic [1:0]           top_sel;

   // Pack an incoming table entry into the memory word
   always_comb begin
      pack_word = '0;
      pack_word[TW-1 -: ACT_W]         = cmd_in.cmd.entry.act;
      pack_word[TW-1-ACT_W -: CNT_W]   = cmd_in.cmd.entry.cnt;
      for (int i = 0; i < PUSH_SLOTS; i++) begin
         pack_word[SYM_W*i +: SYM_W] = cmd_in.cmd.entry.syms[i];
      end
   end

   // Unpack the entry read back from the table
   always_comb begin
      ent     = '0;
      ent.act = tbl_q_ff[TW-1 -: ACT_W];
      ent.cnt = tbl_q_ff[TW-1-ACT_W -: CNT_W];
      for (int i = 0; i < PUSH_SLOTS; i++) begin
         ent.syms[i] = tbl_q_ff[SYM_W*i +: SYM_W];
      end
   end

   assign step_over = ({1'b0, steps_ff} + 1'b1) > {1'b0, limit_ff};
   assign repl_sum  = (SP_W+1)'(sp_ff) + (SP_W+1)'(ent.cnt);
   assign repl_ovf  = repl_sum > (SP_W+1)'(STACK_DEPTH + 1);
   assign sp_less   = sp_ff - 1'b1;
   assign push_addr = base_ff + SP_W'(idx_ff);
   assign top_sel   = 2'(ent.cnt - 3'd1);

   always_comb begin
      state_in     = state_ff;
      sp_in        = sp_ff;
      top_in       = top_ff;
      stale_in     = stale_ff;
      verdict_in   = verdict_ff;
      cause_in     = cause_ff;
      steps_in     = steps_ff;
      look_in      = look_ff;
      look_ok_in   = look_ok_ff;
      idx_in       = idx_ff;
      base_in      = base_ff;
      clr_addr_in  = clr_addr_ff;
      cmd_pop      = 1'b0;
      emit         = 1'b0;
      emit_verdict = VERD_PARSING;
      emit_cause   = CAUSE_NONE;
      tbl_we       = 1'b0;
      tbl_waddr    = {cmd_in.cmd.top[RW-1:0], cmd_in.cmd.look};
      tbl_wdata    = pack_word;
      tbl_re       = 1'b0;
      tbl_raddr    = {top_ff[RW-1:0], look_ff};
      stk_we       = 1'b0;
      stk_waddr    = push_addr[SA_W-1:0];
      stk_wdata    = ent.syms[idx_ff];
      stk_re       = 1'b0;
      stk_raddr    = sp_less[SA_W-1:0];

      case (state_ff)
         ST_CLEAR: begin
            tbl_we      = 1'b1;
            tbl_waddr   = clr_addr_ff;
            tbl_wdata   = '0;
            clr_addr_in = TA_W'(clr_addr_ff + 1'b1);
            if (clr_addr_ff == TA_W'(TBL_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_in.valid && !rsp_full) begin
               cmd_pop = 1'b1;
               case (cmd_in.cmd.op)
                  OP_TWRITE: begin
                     tbl_we = 1'b1;
                     emit   = 1'b1;
                  end
                  OP_START: begin
                     sp_in      = SP_W'(2);
                     verdict_in = VERD_PARSING;
                     cause_in   = CAUSE_NONE;
                     top_in     = start_ff;
                     stale_in   = 1'b0;
                     stk_we     = 1'b1;
                     stk_waddr  = SA_W'(0);
                     stk_wdata  = bottom_ff;
                     emit       = 1'b1;
                     state_in   = ST_START2;
                  end
                  OP_SYMBOL: begin
                     if (verdict_ff != VERD_PARSING) begin
                        emit         = 1'b1;
                        emit_verdict = verdict_ff;
                        emit_cause   = cause_ff;
                     end else begin
                        look_in    = cmd_in.cmd.look;
                        look_ok_in = cmd_in.cmd.look_ok;
                        steps_in   = '0;
                        state_in   = ST_LOOK;
                     end
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end
         ST_START2: begin
            stk_we    = 1'b1;
            stk_waddr = SA_W'(1);
            stk_wdata = start_ff;
            state_in  = ST_IDLE;
         end
         ST_LOOK: begin
            if (sp_ff == '0) begin
               verdict_in   = VERD_REJECT;
               cause_in     = CAUSE_UNDERFLOW;
               emit         = 1'b1;
               emit_verdict = VERD_REJECT;
               emit_cause   = CAUSE_UNDERFLOW;
               state_in     = ST_IDLE;
            end else if (stale_ff) begin
               stk_re   = 1'b1;
               state_in = ST_TOPRD;
            end else if (!look_ok_ff || int'(top_ff) >= SYMBOL_COUNT) begin
               verdict_in   = VERD_REJECT;
               cause_in     = CAUSE_TABLE;
               emit         = 1'b1;
               emit_verdict = VERD_REJECT;
               emit_cause   = CAUSE_TABLE;
               state_in     = ST_IDLE;
            end else begin
               tbl_re   = 1'b1;
               state_in = ST_ACT;
            end
         end
         ST_TOPRD: begin
            top_in   = stk_q_ff;
            stale_in = 1'b0;
            state_in = ST_LOOK;
         end
         ST_ACT: begin
            case (ent.act)
               ACT_ACCEPT: begin
                  verdict_in   = VERD_ACCEPT;
                  cause_in     = CAUSE_NONE;
                  emit         = 1'b1;
                  emit_verdict = VERD_ACCEPT;
                  state_in     = ST_IDLE;
               end
               ACT_POP_ADVANCE: begin
                  sp_in    = sp_less;
                  stale_in = 1'b1;
                  emit     = 1'b1;
                  state_in = ST_IDLE;
               end
               ACT_POP_RETAIN: begin
                  sp_in    = sp_less;
                  stale_in = 1'b1;
                  if (step_over) begin
                     verdict_in   = VERD_REJECT;
                     cause_in     = CAUSE_STEPS;
                     emit         = 1'b1;
                     emit_verdict = VERD_REJECT;
                     emit_cause   = CAUSE_STEPS;
                     state_in     = ST_IDLE;
                  end else begin
                     steps_in = LIMIT_W'(steps_ff + 1'b1);
                     state_in = ST_LOOK;
                  end
               end
               ACT_REPLACE: begin
                  if (repl_ovf) begin
                     verdict_in   = VERD_REJECT;
                     cause_in     = CAUSE_OVERFLOW;
                     emit         = 1'b1;
                     emit_verdict = VERD_REJECT;
                     emit_cause   = CAUSE_OVERFLOW;
                     state_in     = ST_IDLE;
                  end else begin
                     sp_in = SP_W'(repl_sum - 1'b1);
                     if (ent.cnt == '0) begin
                        stale_in = 1'b1;
                     end else begin
                        top_in   = ent.syms[top_sel];
                        stale_in = 1'b0;
                     end
                     if (step_over) begin
                        // Stack contents no longer matter once rejected
                        verdict_in   = VERD_REJECT;
                        cause_in     = CAUSE_STEPS;
                        emit         = 1'b1;
                        emit_verdict = VERD_REJECT;
                        emit_cause   = CAUSE_STEPS;
                        state_in     = ST_IDLE;
                     end else begin
                        steps_in = LIMIT_W'(steps_ff + 1'b1);
                        if (ent.cnt == '0) begin
                           state_in = ST_LOOK;
                        end else begin
                           stk_we    = 1'b1;
                           stk_waddr = sp_less[SA_W-1:0];
                           stk_wdata = ent.syms[0];
                           base_in   = sp_less;
                           idx_in    = 2'd1;
                           state_in  = (ent.cnt == 3'd1) ? ST_LOOK : ST_PUSH;
                        end
                     end
                  end
               end
               default: begin
                  verdict_in   = VERD_REJECT;
                  cause_in     = CAUSE_TABLE;
                  emit         = 1'b1;
                  emit_verdict = VERD_REJECT;
                  emit_cause   = CAUSE_TABLE;
                  state_in     = ST_IDLE;
               end
            endcase
         end
         ST_PUSH: begin
            stk_we = 1'b1;
            idx_in = idx_ff + 2'd1;
            if (3'(idx_ff) == ent.cnt - 3'd1) begin
               state_in = ST_LOOK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign sp_wide              = (SP_W+DEPTH_W)'(sp_in);
   assign rsp_out.valid        = emit;
   assign rsp_out.rsp.verdict  = emit_verdict;
   assign rsp_out.rsp.cause    = emit_cause;
   assign rsp_out.rsp.depth    = sp_wide[DEPTH_W-1:0];
   assign clearing             = (state_ff == ST_CLEAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         bottom_ff <= RST_BOTTOM;
         start_ff  <= RST_START;
         limit_ff  <= RST_LIMIT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BOTTOM: bottom_ff <= csr_wdata[SYM_W-1:0];
            CSR_START:  start_ff  <= csr_wdata[SYM_W-1:0];
            CSR_LIMIT:  limit_ff  <= csr_wdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         sp_ff       <= '0;
         stale_ff    <= 1'b1;
         verdict_ff  <= VERD_PARSING;
         cause_ff    <= CAUSE_NONE;
         steps_ff    <= '0;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         sp_ff       <= sp_in;
         stale_ff    <= stale_in;
         verdict_ff  <= verdict_in;
         cause_ff    <= cause_in;
         steps_ff    <= steps_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff     <= top_in;
      look_ff    <= look_in;
      look_ok_ff <= look_ok_in;
      idx_ff     <= idx_in;
      base_ff    <= base_in;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_ram[tbl_waddr] <= tbl_wdata;
      end
      if (tbl_re) begin
         tbl_q_ff <= tbl_ram[tbl_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_ram[stk_waddr] <= stk_wdata;
      end
      if (stk_re) begin
         stk_q_ff <= stk_ram[stk_raddr];
      end
   end

   `ASSERT_PROP(a_rsp_room, clock, reset, rsp_out.valid |-> !rsp_full, "result beat into full queue")
   `ASSERT_PROP(a_pop_idle, clock, reset, cmd_pop |-> (state_ff == ST_IDLE && cmd_in.valid), "command taken while busy")
   `ASSERT_PROP(a_sp_range, clock, reset, int'(sp_ff) <= STACK_DEPTH, "stack pointer beyond depth")
   `ASSERT_PROP(a_verdict_hold, clock, reset, (verdict_ff != VERD_PARSING && !(cmd_pop && cmd_in.cmd.op == OP_START)) |=> $stable(verdict_ff), "verdict changed without start")
   `ASSERT_NEVER(a_no_use_clear, clock, reset, clearing && (cmd_pop || tbl_re || stk_we), "engine active during table clear")

endmodule

// File: src/ll1tpe_rsp_queue.sv
// ----------------------------------------------------------------------------
// LL(1) parse engine result queue
// Two-entry queue that holds result beats until the consumer pops them.
// ----------------------------------------------------------------------------
module ll1tpe_rsp_queue import ll1tpe_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  rsp_beat_type  rsp_in,
   output logic          full,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output rsp_type       rsp_head
);

   rsp_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop_ok;

   assign full      = (count_ff == 2'd2);
   assign rsp_empty = (count_ff == 2'd0);
   assign pop_ok    = rsp_pop && !rsp_empty;
   assign rsp_head  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = rsp_in.valid ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (rsp_in.valid && !pop_ok) begin
         count_in = count_ff + 2'd1;
      end else if (!rsp_in.valid && pop_ok) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_in.valid) begin
         q_ff[wr_ptr_ff] <= rsp_in.rsp;
      end
   end

endmodule

// File: src/ll1_table_parse_engine.sv
// ----------------------------------------------------------------------------
// LL(1) table parse engine
// Table-driven predictive pushdown parser with queue-style request and result
// channels and a plain register write port.
// ----------------------------------------------------------------------------
// Every request beat yields exactly one result beat, in order. Kind 0 writes
// one parse table entry (row = top symbol, column = lookahead), kind 1 starts
// a parse by pushing the bottom and start symbols, kind 2 feeds one input
// symbol; the result carries the verdict (parsing, accept, reject), the
// reject cause and the stack depth. After reset the engine clears the parse
// table to reject, one entry a cycle, and req_full stays high until the clear
// is done. A live symbol is taken from the command queue, then each table
// lookup reads the table and decodes the entry; pushed symbols beyond the
// first are written to the stack in turn, the stack top is refetched from
// the stack after any pop or empty replace, and an empty-stack or
// out-of-range check ends the symbol without a lookup. The table has a
// single read port and the symbol stack takes one write a cycle. A two-entry
// command queue before the engine and a two-entry result queue after it let
// request and result sides stall independently.
// ----------------------------------------------------------------------------
module ll1_table_parse_engine import ll1tpe_pkg::*; #(
   parameter int SYMBOL_COUNT = 32,
   parameter int STACK_DEPTH  = 64,
   parameter int MAX_PUSH     = 4
) (
   input  logic                  clock,
   input  logic                  reset,

   // Request channel
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [SYM_W-1:0]      req_top_symbol,
   input  logic [SYM_W-1:0]      req_look_symbol,
   input  logic [ACT_W-1:0]      req_action,
   input  logic [CNT_W-1:0]      req_push_count,
   input  logic [SYM_W-1:0]      req_push_first,
   input  logic [SYM_W-1:0]      req_push_second,
   input  logic [SYM_W-1:0]      req_push_third,
   input  logic [SYM_W-1:0]      req_push_fourth,

   // Result channel
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [VERD_W-1:0]     rsp_verdict,
   output logic [CAUSE_W-1:0]    rsp_reject_cause,
   output logic [DEPTH_W-1:0]    rsp_stack_depth,

   // Configuration write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_beat_type cmd_beat;
   logic         cmd_pop;
   rsp_beat_type rsp_beat;
   logic         rsp_full;
   logic         clearing;
   rsp_type      rsp_head;

   // Front: accept and classify request beats; hold them off during clear
   ll1tpe_front #(
      .SYMBOL_COUNT (SYMBOL_COUNT),
      .MAX_PUSH     (MAX_PUSH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .hold            (clearing),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_kind        (req_kind),
      .req_top_symbol  (req_top_symbol),
      .req_look_symbol (req_look_symbol),
      .req_action      (req_action),
      .req_push_count  (req_push_count),
      .req_push_first  (req_push_first),
      .req_push_second (req_push_second),
      .req_push_third  (req_push_third),
      .req_push_fourth (req_push_fourth),
      .cmd_out         (cmd_beat),
      .cmd_pop         (cmd_pop)
   );

   // Back: table, stack and step sequencer; take a command only with result room
   ll1tpe_back #(
      .SYMBOL_COUNT (SYMBOL_COUNT),
      .STACK_DEPTH  (STACK_DEPTH),
      .MAX_PUSH     (MAX_PUSH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_in    (cmd_beat),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_out   (rsp_beat),
      .clearing  (clearing)
   );

   // Result queue: hold finished beats until popped
   ll1tpe_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .rsp_in    (rsp_beat),
      .full      (rsp_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_head  (rsp_head)
   );

   assign rsp_verdict      = rsp_head.verdict;
   assign rsp_reject_cause = rsp_head.cause;
   assign rsp_stack_depth  = rsp_head.depth;

endmodule
